[rtl/core/httpread_payload_deframer_unit_macros.svh]
// Assertion macros used by the deframer checker.
`ifndef HTTPREAD_PAYLOAD_DEFRAMER_UNIT_MACROS_SVH
`define HTTPREAD_PAYLOAD_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HPD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hpd_pkg.sv]
// Package: types, marker tables and codes of the HTTPREAD payload deframer.
package hpd_pkg;

  localparam int BUF_BYTES = 1024;
  localparam logic [10:0] LEN_CAP = 11'd1024;
  localparam logic [10:0] LIMIT_CAP = (BUF_BYTES < 1024) ? 11'(BUF_BYTES) : LEN_CAP;

  localparam int HOLD_DEPTH = 14;
  localparam logic [3:0] HOLD_FULL = 4'd14;
  localparam logic [3:0] START_LAST = 4'd15;
  localparam logic [3:0] END_LAST = 4'd13;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_CRLF = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_START = 3'd1;
  localparam logic [2:0] ST_NO_END = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic        last;
    logic [10:0] len;
    logic [2:0]  st;
    logic [7:0]  data;
    logic        kind;
  } result_t;

  // "+HTTPREAD: DATA,"
  function automatic logic [7:0] start_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2B;
      4'd1:    c = 8'h48;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h52;
      4'd6:    c = 8'h45;
      4'd7:    c = 8'h41;
      4'd8:    c = 8'h44;
      4'd9:    c = 8'h3A;
      4'd10:   c = 8'h20;
      4'd11:   c = 8'h44;
      4'd12:   c = 8'h41;
      4'd13:   c = 8'h54;
      4'd14:   c = 8'h41;
      4'd15:   c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // CR LF "+HTTPREAD: 0"
  function automatic logic [7:0] end_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h0D;
      4'd1:    c = 8'h0A;
      4'd2:    c = 8'h2B;
      4'd3:    c = 8'h48;
      4'd4:    c = 8'h54;
      4'd5:    c = 8'h54;
      4'd6:    c = 8'h50;
      4'd7:    c = 8'h52;
      4'd8:    c = 8'h45;
      4'd9:    c = 8'h41;
      4'd10:   c = 8'h44;
      4'd11:   c = 8'h3A;
      4'd12:   c = 8'h20;
      4'd13:   c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/httpread_payload_deframer_unit.sv]
// Top level: HTTPREAD response payload deframer with status reporting.
//
// channel | dir | tdata                              | tuser | tlast
// s_axis  | in  | [7:0] in_byte                      | -     | last_byte
// m_axis  | out | [7:0] byte [10:8] status [21:11] len | kind  | is_last
// cfg     | in  | cfg_wdata = max_len, on cfg_we     | -     | -
//
// One input transaction a cycle: input register, one pass of match logic,
// then a 4-entry result queue. A final byte can push two results, so the
// queue must have two free entries before a byte leaves the input register.
// rst is synchronous; it clears control state and sets max_len to 1024.
// A stalled m_axis backs up into s_axis tready through the queue.
module httpread_payload_deframer_unit
  import hpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status,
                                      // [21:11] payload_length, [23:22] zero
  output logic [0:0]  m_axis_tuser,   // [0] out_kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [10:0] max_len;

  logic        stage_valid;
  logic [7:0]  stage_data;
  logic        stage_last;
  logic        advance;

  logic [1:0]  phase, phase_next;
  logic [3:0]  spos, spos_next;
  logic [3:0]  epos, epos_next;
  logic [3:0]  fill, fill_next;
  logic [10:0] count, count_next;
  logic [2:0]  fstat, fstat_next;
  logic [7:0]  hb [HOLD_DEPTH];
  logic [7:0]  hb_next [HOLD_DEPTH];

  logic [10:0] lim;
  logic        emit;
  result_t     pay_item, stat_item;
  logic [2:0]  st;
  logic [10:0] len;

  result_t     fifo [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fifo_cnt;
  logic          pop;
  logic [1:0]    push_n;

  assign lim = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
  assign advance = stage_valid && (fifo_cnt <= (PW+1)'(FIFO_DEPTH - 2));
  assign s_axis_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_CAP;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stage_data <= s_axis_tdata;
      stage_last <= s_axis_tlast;
    end
  end

  always_comb begin
    phase_next = phase;
    spos_next  = spos;
    epos_next  = epos;
    fill_next  = fill;
    count_next = count;
    fstat_next = fstat;
    hb_next    = hb;
    emit       = 1'b0;
    st         = ST_OK;
    len        = '0;

    case (phase)
      PH_START: begin
        if (stage_data == start_char(spos)) begin
          if (spos == START_LAST) begin
            phase_next = PH_CRLF;
            spos_next  = '0;
          end else begin
            spos_next = spos + 4'd1;
          end
        end else begin
          spos_next = (stage_data == CH_PLUS) ? 4'd1 : 4'd0;
        end
      end
      PH_CRLF: begin
        if (stage_data == (spos[0] ? CH_LF : CH_CR)) begin
          if (spos[0]) begin
            phase_next = PH_DATA;
            spos_next  = '0;
            epos_next  = '0;
            fill_next  = '0;
            count_next = '0;
          end else begin
            spos_next = 4'd1;
          end
        end else begin
          spos_next = (stage_data == CH_CR) ? 4'd1 : 4'd0;
        end
      end
      PH_DATA: begin
        if (fill == HOLD_FULL) begin
          emit = (count < lim);
          if (count <= LEN_CAP) begin
            count_next = count + 11'd1;
          end
          for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            hb_next[i] = hb[i+1];
          end
          hb_next[HOLD_DEPTH-1] = stage_data;
        end else begin
          hb_next[fill] = stage_data;
          fill_next = fill + 4'd1;
        end
        if (stage_data == end_char(epos)) begin
          if (epos == END_LAST) begin
            phase_next = PH_DONE;
            epos_next  = '0;
            fill_next  = '0;
            if (count_next == 11'd0) begin
              fstat_next = ST_EMPTY;
            end else if (count_next > lim) begin
              fstat_next = ST_TOO_LONG;
            end else begin
              fstat_next = ST_OK;
            end
          end else begin
            epos_next = epos + 4'd1;
          end
        end else begin
          epos_next = (stage_data == CH_CR) ? 4'd1 : 4'd0;
        end
      end
      default: begin
      end
    endcase

    case (phase_next)
      PH_START, PH_CRLF: st = ST_NO_START;
      PH_DATA:           st = ST_NO_END;
      default:           st = fstat_next;
    endcase
    if (st == ST_OK || st == ST_TOO_LONG) begin
      len = (count_next > LEN_CAP) ? LEN_CAP : count_next;
    end

    if (stage_last) begin
      phase_next = PH_START;
      spos_next  = '0;
      epos_next  = '0;
      fill_next  = '0;
      count_next = '0;
      fstat_next = ST_OK;
    end
  end

  always_comb begin
    pay_item      = '0;
    pay_item.data = hb[0];
    stat_item      = '0;
    stat_item.kind = 1'b1;
    stat_item.st   = st;
    stat_item.len  = len;
    stat_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      spos  <= '0;
      epos  <= '0;
      fill  <= '0;
      count <= '0;
      fstat <= ST_OK;
    end else if (advance) begin
      phase <= phase_next;
      spos  <= spos_next;
      epos  <= epos_next;
      fill  <= fill_next;
      count <= count_next;
      fstat <= fstat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hb <= hb_next;
    end
  end

  // Result queue
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign push_n = advance ? ({1'b0, emit} + {1'b0, stage_last}) : 2'd0;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (emit) begin
        fifo[wr_ptr] <= pay_item;
      end
      if (stage_last) begin
        fifo[wr_ptr + PW'(emit)] <= stat_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      wr_ptr   <= wr_ptr + PW'(push_n);
      rd_ptr   <= rd_ptr + PW'(pop);
      fifo_cnt <= fifo_cnt + (PW+1)'(push_n) - (PW+1)'(pop);
    end
  end

  assign m_axis_tvalid   = (fifo_cnt != '0);
  assign m_axis_tdata    = {2'b00, fifo[rd_ptr].len, fifo[rd_ptr].st, fifo[rd_ptr].data};
  assign m_axis_tuser[0] = fifo[rd_ptr].kind;
  assign m_axis_tlast    = fifo[rd_ptr].last;

endmodule

[rtl/core/hpd_checker.sv]
// Port-level checker for the HTTPREAD payload deframer, with its bind.
`include "httpread_payload_deframer_unit_macros.svh"

module hpd_checker
  import hpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `HPD_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "m_axis transaction changed while stalled")

  `HPD_ASSERT_NOW(a_last_is_status, clk, rst, m_axis_tvalid, m_axis_tlast == m_axis_tuser[0], "tlast does not match the status kind")

  `HPD_ASSERT_NOW(a_payload_clean, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[23:8] == 16'd0, "payload transaction carries status bits")

  `HPD_ASSERT_NOW(a_status_legal, clk, rst, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[10:8] <= ST_TOO_LONG) && (m_axis_tdata[21:11] <= LEN_CAP) && ((m_axis_tdata[21:11] == 11'd0) || (m_axis_tdata[10:8] == ST_OK) || (m_axis_tdata[10:8] == ST_TOO_LONG)), "malformed status transaction")

endmodule

bind httpread_payload_deframer_unit hpd_checker u_hpd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/httpread_payload_deframer_unit_tb.sv]
// Testbench for the HTTPREAD payload deframer: framed byte stimulus, predictor, result checks.
module httpread_payload_deframer_unit_tb
  import hpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FR_GOOD, FR_TRAIL, FR_NO_END, FR_NO_CRLF, FR_NO_START, FR_NOISE}
    frame_kind_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam bit [127:0] START_PAT = "+HTTPREAD: DATA,";
  localparam bit [111:0] END_PAT = {8'h0D, 8'h0A, "+HTTPREAD: 0"};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // [7:0] out_byte, [10:8] status,
                                        // [21:11] payload_length
  logic [0:0]  m_axis_tuser;            // [0] out_kind
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = 11'd0;

  httpread_payload_deframer_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [1:0]  ph;
  int          scan_pos;
  int          tail_pos;
  logic [7:0]  hold_q[$];
  int          pay_cnt;
  logic [2:0]  done_st;
  logic [10:0] max_len_q;
  result_t     exp_q[$];

  logic idle_on;
  int   sent_cnt;
  int   err_cnt;
  int   sink_hold;

  function automatic logic [7:0] start_sym(input int i);
    return START_PAT[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] end_sym(input int i);
    return END_PAT[111 - 8 * i -: 8];
  endfunction

  function automatic void reset_frame();
    ph = PH_START;
    scan_pos = 0;
    tail_pos = 0;
    hold_q.delete();
    pay_cnt = 0;
    done_st = ST_OK;
  endfunction

  function automatic void push_exp(input logic kind, input logic [7:0] data,
                                   input logic [2:0] st, input logic [10:0] len,
                                   input logic lst);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.st = st;
    r.len = len;
    r.last = lst;
    exp_q.push_back(r);
  endfunction

  function automatic void deframe(input logic [7:0] b, input logic lst);
    logic [10:0] lim;
    logic [2:0]  st;
    logic [10:0] len;
    logic [7:0]  oldest;
    lim = (max_len_q > LIMIT_CAP) ? LIMIT_CAP : max_len_q;
    len = '0;
    case (ph)
      PH_START: begin
        if (scan_pos < 16 && b == start_sym(scan_pos)) scan_pos++;
        else scan_pos = (b == CH_PLUS) ? 1 : 0;
        if (scan_pos >= 16) begin
          ph = PH_CRLF;
          scan_pos = 0;
        end
      end
      PH_CRLF: begin
        if (scan_pos < 2 && b == ((scan_pos == 0) ? CH_CR : CH_LF)) scan_pos++;
        else scan_pos = (b == CH_CR) ? 1 : 0;
        if (scan_pos >= 2) begin
          ph = PH_DATA;
          scan_pos = 0;
          tail_pos = 0;
          hold_q.delete();
          pay_cnt = 0;
        end
      end
      PH_DATA: begin
        if (hold_q.size() >= HOLD_DEPTH) begin
          oldest = hold_q.pop_front();
          if (pay_cnt < lim) push_exp(KIND_DATA, oldest, ST_OK, 11'd0, 1'b0);
          if (pay_cnt <= LEN_CAP) pay_cnt++;
        end
        hold_q.push_back(b);
        if (tail_pos < 14 && b == end_sym(tail_pos)) tail_pos++;
        else tail_pos = (b == CH_CR) ? 1 : 0;
        if (tail_pos >= 14) begin
          ph = PH_DONE;
          tail_pos = 0;
          hold_q.delete();
          if (pay_cnt == 0) done_st = ST_EMPTY;
          else if (pay_cnt > lim) done_st = ST_TOO_LONG;
          else done_st = ST_OK;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (ph == PH_START || ph == PH_CRLF) begin
        st = ST_NO_START;
      end else if (ph == PH_DATA) begin
        st = ST_NO_END;
      end else begin
        st = done_st;
        if (st == ST_OK || st == ST_TOO_LONG)
          len = (pay_cnt > LEN_CAP) ? LEN_CAP : 11'(pay_cnt);
      end
      push_exp(KIND_STATUS, 8'h00, st, len, 1'b1);
      reset_frame();
    end
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d byte=%02h status=%0d len=%0d last=%0d",
                     r.kind, r.data, r.st, r.len, r.last);
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.kind = m_axis_tuser[0];
    got.data = m_axis_tdata[7:0];
    got.st = m_axis_tdata[10:8];
    got.len = m_axis_tdata[21:11];
    got.last = m_axis_tlast;
    if (exp_q.size() == 0) begin
      if (err_cnt < 10) $display("%0t: unexpected result %s", $time, fmt_result(got));
      err_cnt++;
    end else begin
      want = exp_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.st !== want.st ||
          got.len !== want.len || got.last !== want.last) begin
        if (err_cnt < 10)
          $display("%0t: mismatch expected %s actual %s", $time, fmt_result(want),
                   fmt_result(got));
        err_cnt++;
      end
    end
  endfunction

  // result side: check each transaction, stall in bursts
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      sink_hold = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= lst;
    do @(posedge clk); while (!s_axis_tready);
    deframe(b, lst);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [10:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_q = v;
  endtask

  task automatic send_pat(input bit [127:0] pat, input int n, input int upto,
                          input bit lst_at_end);
    for (int i = 0; i < upto; i++)
      send_byte(pat[8 * n - 1 - 8 * i -: 8], lst_at_end && i == upto - 1);
  endtask

  function automatic logic [7:0] payload_sym();
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0: b = CH_CR;
      1: b = CH_LF;
      2: b = CH_PLUS;
      3: b = 8'h00;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // payload with occasional partial end markers
  task automatic send_payload(input int n);
    int i;
    int k;
    i = 0;
    while (i < n) begin
      if ($urandom_range(0, 29) == 0) begin
        k = $urandom_range(1, 13);
        if (k > n - i) k = n - i;
        send_pat(END_PAT, 14, k, 1'b0);
        i += k;
      end else begin
        send_byte(payload_sym(), 1'b0);
        i++;
      end
    end
  endtask

  task automatic send_junk(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_pat(START_PAT, 16, $urandom_range(1, 15), 1'b0);
      else send_byte(payload_sym(), 1'b0);
    end
  endtask

  task automatic send_frame(input frame_kind_t k, input int pay_n);
    if (k == FR_NOISE) begin
      send_junk($urandom_range(1, 20));
      send_byte(payload_sym(), 1'b1);
      return;
    end
    send_junk($urandom_range(0, 3));
    if (k == FR_NO_START) begin
      send_pat(START_PAT, 16, $urandom_range(1, 15), 1'b0);
      send_byte(payload_sym(), 1'b1);
      return;
    end
    send_pat(START_PAT, 16, 16, 1'b0);
    repeat ($urandom_range(0, 3)) send_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    if (k == FR_NO_CRLF) begin
      if ($urandom_range(0, 1)) send_byte(CH_CR, 1'b0);
      send_byte(8'h30, 1'b1);
      return;
    end
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_payload(pay_n);
    if (k == FR_NO_END) begin
      send_byte(payload_sym(), 1'b1);
      return;
    end
    send_pat(END_PAT, 14, 14, k == FR_GOOD);
    if (k == FR_TRAIL) begin
      repeat ($urandom_range(0, 4)) send_byte(payload_sym(), 1'b0);
      send_byte(payload_sym(), 1'b1);
    end
  endtask

  task automatic test_missing_markers();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_pat(START_PAT, 16, 16, 1'b1);
    send_pat(START_PAT, 16, 16, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b1);
  endtask

  task automatic test_empty_payload();
    send_frame(FR_GOOD, 0);
    send_frame(FR_TRAIL, 0);
  endtask

  task automatic test_length_limits();
    set_limit(11'd1);
    send_frame(FR_GOOD, 1);
    send_frame(FR_GOOD, 2);
    set_limit(11'd0);
    send_frame(FR_GOOD, 1);
    set_limit(11'd2047);
    send_frame(FR_GOOD, 3);
  endtask

  task automatic test_random_frames(input int n_items);
    int target;
    int r;
    int pay_n;
    target = sent_cnt + n_items;
    while (sent_cnt < target) begin
      r = $urandom_range(0, 19);
      pay_n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 24);
      if (r < 12) send_frame(FR_GOOD, pay_n);
      else if (r < 14) send_frame(FR_TRAIL, pay_n);
      else if (r < 16) send_frame(FR_NO_END, pay_n);
      else if (r == 16) send_frame(FR_NO_CRLF, pay_n);
      else if (r == 17) send_frame(FR_NO_START, pay_n);
      else send_frame(FR_NOISE, pay_n);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    idle_on = 1'b1;
    sent_cnt = 0;
    err_cnt = 0;
    sink_hold = 0;
    max_len_q = 11'd1024;
    reset_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_missing_markers();
    test_empty_payload();
    test_length_limits();

    set_limit(11'd1024);
    test_random_frames(150);
    set_limit(11'($urandom_range(1, 16)));
    test_random_frames(150);
    set_limit(11'd2047);
    test_random_frames(100);
    set_limit(11'd1);
    test_random_frames(100);
    set_limit(11'($urandom_range(17, 64)));
    test_random_frames(150);

    // back-to-back tail with no idling on either side
    set_limit(11'($urandom_range(1, 30)));
    idle_on = 1'b0;
    test_random_frames(150);

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
